[sv/bpe_pkg.sv]
// ----------------------------------------------------------------------------
// bpe_pkg: shared types for the Bezier point evaluator
// Holds the sequencer state encoding, the coordinate width and the control
// bundle that the sequencer hands to the top level.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // Width of one signed Q16.16 coordinate.
  localparam int unsigned COORD_W = 32;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT_OUT,
    ST_PASS,
    ST_GAP,
    ST_DRAIN
  } bpe_state_t;

  // Control from the sequencer to the stores and the output register.
  typedef struct packed {
    logic wr_en;      // write one entry of both stores
    logic wr_lerp;    // write data comes from the lerp lanes, else from the input
    logic rd_en;      // read one entry of both stores
    logic load_pick;  // load the output register from the store read data
    logic load_lerp;  // load the output register from the lerp lanes
  } bpe_ctl_t;

endpackage

[sv/bpe_store.sv]
// ----------------------------------------------------------------------------
// bpe_store: control point memory
// Synchronous single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module bpe_store
  import bpe_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [COORD_W-1:0]         wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [COORD_W-1:0]         rd_data
);

  logic [COORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/bpe_lerp.sv]
// ----------------------------------------------------------------------------
// bpe_lerp: one coordinate lane of the linear interpolation pipeline
// Computes p + floor((q - p) * t / 2^T_FRAC_BITS), where q is the word just
// read from the store and p the word read before it.
// ----------------------------------------------------------------------------
module bpe_lerp
  import bpe_pkg::*;
#(
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [COORD_W-1:0]         rd_data,
  input  logic [T_FRAC_BITS:0]       t_val,
  output logic [COORD_W-1:0]         result
);

  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = DIFF_W + T_FRAC_BITS + 2;

  logic signed [COORD_W-1:0] prev;
  logic signed [DIFF_W-1:0]  diff1;
  logic signed [COORD_W-1:0] p1;
  logic signed [PROD_W-1:0]  prod2;
  logic signed [COORD_W-1:0] p2;
  logic signed [PROD_W-1:0]  scaled;

  // Keep the previous read word as the left point of the next step.
  always_ff @(posedge clk) begin
    if (load) begin
      prev <= $signed(rd_data);
    end
  end

  // Stage one takes the difference, stage two the product.
  always_ff @(posedge clk) begin
    diff1 <= $signed({rd_data[COORD_W-1], rd_data}) - $signed({prev[COORD_W-1], prev});
    p1    <= prev;
    prod2 <= PROD_W'(diff1 * $signed({1'b0, t_val}));
    p2    <= p1;
  end

  // The arithmetic shift is the floor; the sum stays inside the 32-bit range.
  assign scaled = prod2 >>> T_FRAC_BITS;
  assign result = COORD_W'(p2) + scaled[COORD_W-1:0];

endmodule

[sv/bpe_ctrl.sv]
// ----------------------------------------------------------------------------
// bpe_ctrl: point counter and de Casteljau sequencer
// Counts incoming points, then walks the stores pass by pass, issuing one
// read per cycle within a pass, and tracking each step down the lerp
// pipeline to its write-back address.
// ----------------------------------------------------------------------------
module bpe_ctrl
  import bpe_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 16,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_last,
  input  logic [T_FRAC_BITS:0]          in_t,
  input  logic                          out_busy,
  output logic                          in_ready,
  output bpe_ctl_t                      ctl,
  output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic [T_FRAC_BITS:0]          t_eval,
  output logic                          ovf_eval
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW = T_FRAC_BITS + 1;

  bpe_state_t     state, state_next;
  logic [CW-1:0]  count, count_next;
  logic           ovf_seen, ovf_seen_next;
  logic [CW-1:0]  n_eval, n_eval_next;
  logic [TW-1:0]  t_eval_next;
  logic           ovf_eval_next;
  logic [CW-1:0]  len, len_next;
  logic [AW-1:0]  addr, addr_next;

  // Tags of the read in flight and of the two lerp stages.
  logic           rv, r_first, r_fin, r_pick;
  logic [AW-1:0]  r_addr;
  logic           v1, fin1, v2, fin2;
  logic [AW-1:0]  a1, a2;

  logic           iss_first, iss_fin, iss_pick;
  logic           rd_issue;
  logic           accept, room, pipe_idle;
  logic [CW-1:0]  n_last, len_last;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign room      = (count < CW'(MAX_POINTS));
  assign pipe_idle = !rv && !v1 && !v2;
  assign n_last    = n_eval - CW'(1);
  assign len_last  = len - CW'(1);

  // Write port: input points while idle, lerp results during evaluation.
  assign ctl.wr_lerp   = v2;
  assign ctl.wr_en     = v2 || (accept && room);
  assign wr_addr       = v2 ? a2 : count[AW-1:0];
  assign ctl.rd_en     = rd_issue;
  assign ctl.load_pick = rv && r_pick;
  assign ctl.load_lerp = v2 && fin2;

  // Next state and read issue.
  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_seen_next = ovf_seen;
    n_eval_next   = n_eval;
    t_eval_next   = t_eval;
    ovf_eval_next = ovf_eval;
    len_next      = len;
    addr_next     = addr;
    rd_issue      = 1'b0;
    rd_addr       = addr;
    iss_first     = 1'b0;
    iss_fin       = 1'b0;
    iss_pick      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_last) begin
            n_eval_next   = room ? count + CW'(1) : count;
            ovf_eval_next = ovf_seen || !room;
            t_eval_next   = in_t;
            count_next    = '0;
            ovf_seen_next = 1'b0;
            state_next    = ST_WAIT_OUT;
          end else if (room) begin
            count_next = count + CW'(1);
          end else begin
            ovf_seen_next = 1'b1;
          end
        end
      end
      ST_WAIT_OUT: begin
        // Start only once the output register is free.
        if (!out_busy) begin
          if (t_eval == '0) begin
            rd_issue   = 1'b1;
            rd_addr    = '0;
            iss_pick   = 1'b1;
            state_next = ST_DRAIN;
          end else if (t_eval[T_FRAC_BITS] || (n_eval == CW'(1))) begin
            rd_issue   = 1'b1;
            rd_addr    = n_last[AW-1:0];
            iss_pick   = 1'b1;
            state_next = ST_DRAIN;
          end else begin
            len_next   = n_eval;
            addr_next  = '0;
            state_next = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        rd_issue  = 1'b1;
        iss_first = (addr == '0);
        iss_fin   = (len == CW'(2)) && (addr == AW'(1));
        if (addr == len_last[AW-1:0]) begin
          addr_next = '0;
          if (len == CW'(2)) begin
            state_next = ST_DRAIN;
          end else begin
            len_next   = len_last;
            state_next = ST_GAP;
          end
        end else begin
          addr_next = addr + AW'(1);
        end
      end
      ST_GAP: begin
        // Short passes must wait for the last write-back of the pass before.
        if ((len >= CW'(3)) || pipe_idle) begin
          state_next = ST_PASS;
        end
      end
      ST_DRAIN: begin
        if (ctl.load_pick || ctl.load_lerp) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ovf_seen <= 1'b0;
      rv       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf_seen <= ovf_seen_next;
      rv       <= rd_issue;
      v1       <= rv && !r_first && !r_pick;
      v2       <= v1;
    end
  end

  // Evaluation operands and tag payloads.
  always_ff @(posedge clk) begin
    n_eval   <= n_eval_next;
    t_eval   <= t_eval_next;
    ovf_eval <= ovf_eval_next;
    len      <= len_next;
    addr     <= addr_next;
    r_first  <= iss_first;
    r_fin    <= iss_fin;
    r_pick   <= iss_pick;
    r_addr   <= rd_addr;
    a1       <= r_addr - AW'(1);
    fin1     <= r_fin;
    a2       <= a1;
    fin2     <= fin1;
  end

endmodule

[sv/bezier_point_evaluator.sv]
// ----------------------------------------------------------------------------
// bezier_point_evaluator: fixed-point Bezier curve point by de Casteljau
// Control points stream in; the transaction marked with tlast closes the
// curve and yields one result point.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one control point per transaction, with the
//   curve parameter t in Q1.T_FRAC_BITS; only t of the tlast transaction is
//   used. Up to MAX_POINTS points are kept; further points are dropped and
//   the result's overflow flag is set. The master channel returns the curve
//   point, with the overflow flag on tuser.
//   Points that are not last leave s_tready high for the next point. After
//   the last point the sequencer runs de Casteljau in place in the x and y
//   stores: a pass over L points issues L reads on the single read port,
//   and a gap state lies between passes, in which a pass of two points waits
//   for the last write-back of the pass before. When t is zero, one or above,
//   or the curve has one point, no pass runs: the first point (t zero) or
//   the last point is read from the stores and loaded into the output register.
//   s_tready is low during evaluation. When the receiver stalls, the result
//   waits in the output register, new points are still taken, and the next
//   evaluation starts only once the output register is free.
//   Reset clears the point count, the overflow state and the output valid;
//   the stores need no clearing, since only entries written for the current
//   curve are ever read.
// ----------------------------------------------------------------------------
module bezier_point_evaluator
  import bpe_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 16,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Slave side; s_tdata from bit 0: t_param, point_x, point_y, zero padding.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [((T_FRAC_BITS + 1 + 2 * COORD_W + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                  s_tlast,   // last_point
  // Master side; m_tdata from bit 0: curve_x, curve_y.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [2*COORD_W-1:0]  m_tdata,
  output logic                  m_tuser    // overflow_flag
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned TW = T_FRAC_BITS + 1;

  bpe_ctl_t            ctl;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [TW-1:0]       t_eval;
  logic                ovf_eval;
  logic [COORD_W-1:0]  in_x, in_y;
  logic [COORD_W-1:0]  rd_x, rd_y;
  logic [COORD_W-1:0]  res_x, res_y;
  logic [COORD_W-1:0]  wr_x, wr_y;

  // Input fields.
  assign in_x = s_tdata[TW +: COORD_W];
  assign in_y = s_tdata[TW + COORD_W +: COORD_W];

  // Sequencer.
  bpe_ctrl #(
    .MAX_POINTS  (MAX_POINTS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_t     (s_tdata[TW-1:0]),
    .out_busy (m_tvalid),
    .in_ready (s_tready),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .t_eval   (t_eval),
    .ovf_eval (ovf_eval)
  );

  // Store write data: incoming point or lerp result.
  assign wr_x = ctl.wr_lerp ? res_x : in_x;
  assign wr_y = ctl.wr_lerp ? res_y : in_y;

  bpe_store #(.DEPTH(MAX_POINTS)) u_store_x (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_x),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_x)
  );

  bpe_store #(.DEPTH(MAX_POINTS)) u_store_y (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_y),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_y)
  );

  // One interpolation lane per coordinate.
  bpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_x (
    .clk     (clk),
    .load    (ctl.rd_en),
    .rd_data (rd_x),
    .t_val   (t_eval),
    .result  (res_x)
  );

  bpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_y (
    .clk     (clk),
    .load    (ctl.rd_en),
    .rd_data (rd_y),
    .t_val   (t_eval),
    .result  (res_y)
  );

  // Output register; valid holds until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load_pick || ctl.load_lerp) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_pick) begin
      m_tdata <= {rd_y, rd_x};
      m_tuser <= ovf_eval;
    end else if (ctl.load_lerp) begin
      m_tdata <= {res_y, res_x};
      m_tuser <= ovf_eval;
    end
  end

endmodule

[verif/bezier_point_evaluator_tb.sv]
// ----------------------------------------------------------------------------
// bezier_point_evaluator_tb: self-checking bench for the Bezier point evaluator
// Streams control-point curves into the slave channel and checks every curve
// point on the master channel against a de Casteljau predictor kept in a
// small scoreboard. Directed curves cover the edges of t and of the point
// values; random curves follow, mostly short, some full and some over
// capacity, under three handshake idling mixes and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// One expected curve point as it leaves the block.
typedef struct packed {
  logic [31:0] x;
  logic [31:0] y;
  logic        ovf;
} curve_point_t;

// Predicts curve points from accepted control points and checks results.
class curve_scoreboard;
  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam longint      T_UNIT      = 64'sd1 << FRAC_BITS;

  longint       xs[STORE_DEPTH];
  longint       ys[STORE_DEPTH];
  int unsigned  n_stored;
  bit           dropped;
  curve_point_t expected_q[$];

  int unsigned  errors;
  int unsigned  points_seen;
  int unsigned  curves_seen;
  int unsigned  overflow_curves;
  int unsigned  results_checked;

  function new();
    n_stored        = 0;
    dropped         = 0;
    errors          = 0;
    points_seen     = 0;
    curves_seen     = 0;
    overflow_curves = 0;
    results_checked = 0;
  endfunction

  // Prints one line per mismatch and counts it.
  task report_mismatch(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  // One linear step with the product floored, as the hardware lerp does.
  function longint lerp_step(longint p, longint q, longint t);
    return p + (((q - p) * t) >>> FRAC_BITS);
  endfunction

  // Full de Casteljau reduction of one coordinate axis.
  function longint reduce_axis(longint src[STORE_DEPTH], int unsigned n, longint t);
    longint      w[STORE_DEPTH];
    int unsigned len;
    w = src;
    for (len = n; len > 1; len--)
      for (int unsigned i = 0; i + 1 < len; i++)
        w[i] = lerp_step(w[i], w[i + 1], t);
    return w[0];
  endfunction

  // Records one accepted control point; on the last point, predicts the result.
  function void note_point(logic [16:0] t_in, logic [31:0] px, logic [31:0] py,
                           bit last);
    longint       t;
    longint       rx;
    longint       ry;
    curve_point_t exp_pt;
    points_seen++;
    if (n_stored < STORE_DEPTH) begin
      xs[n_stored] = longint'($signed(px));
      ys[n_stored] = longint'($signed(py));
      n_stored++;
    end else begin
      dropped = 1;
    end
    if (!last) return;

    t = longint'(t_in);
    if (t > T_UNIT) t = T_UNIT;
    if (t == 0) begin
      rx = xs[0];
      ry = ys[0];
    end else if (t == T_UNIT) begin
      rx = xs[n_stored - 1];
      ry = ys[n_stored - 1];
    end else begin
      rx = reduce_axis(xs, n_stored, t);
      ry = reduce_axis(ys, n_stored, t);
    end
    exp_pt.x   = rx[31:0];
    exp_pt.y   = ry[31:0];
    exp_pt.ovf = dropped;
    expected_q.insert(expected_q.size(), exp_pt);

    curves_seen++;
    if (dropped) overflow_curves++;
    n_stored = 0;
    dropped  = 0;
  endfunction

  // Compares one accepted result with the oldest expected curve point.
  task check_result(logic [63:0] data, logic ovf);
    curve_point_t exp_pt;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %h/%b with no curve pending", data, ovf));
      return;
    end
    exp_pt = expected_q.pop_front();
    results_checked++;
    if (data[31:0] !== exp_pt.x)
      report_mismatch($sformatf("curve %0d curve_x got %h expected %h",
                                results_checked, data[31:0], exp_pt.x));
    if (data[63:32] !== exp_pt.y)
      report_mismatch($sformatf("curve %0d curve_y got %h expected %h",
                                results_checked, data[63:32], exp_pt.y));
    if (ovf !== exp_pt.ovf)
      report_mismatch($sformatf("curve %0d overflow_flag got %b expected %b",
                                results_checked, ovf, exp_pt.ovf));
  endtask

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module bezier_point_evaluator_tb;

  localparam int unsigned MAX_PTS     = 16;
  localparam int unsigned T_BITS      = 16;
  localparam int unsigned CW          = bpe_pkg::COORD_W;
  localparam int unsigned S_W         = ((T_BITS + 1 + 2 * CW + 7) / 8) * 8;
  localparam int unsigned PAD_W       = S_W - (T_BITS + 1 + 2 * CW);
  localparam logic [16:0] T_ONE       = 17'h10000;
  localparam logic [31:0] C_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN       = 32'h8000_0000;
  localparam int unsigned PHASE_ITEMS = 380;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned END_WAIT    = 200;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_W-1:0]      s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [2*CW-1:0]     m_tdata;
  logic                m_tuser;

  curve_scoreboard sb = new();

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 73;
  bit          hold_req      = 1'b0;
  int unsigned cycle_count   = 0;

  bezier_point_evaluator #(
    .MAX_POINTS (MAX_PTS),
    .T_FRAC_BITS(T_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Clock with a 10 ns period.
  always #5 clk = ~clk;

  // Cycle counter and timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d curve points outstanding",
               cycle_count, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: checks each accepted transaction and paces m_tready,
  // including one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Random coordinate with the extremes showing up often.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(15))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Parameter for the closing point: exact ends, above one, near ends, mid.
  function automatic logic [16:0] rand_last_t();
    case ($urandom_range(9))
      0:       return 17'd0;
      1:       return T_ONE;
      2:       return 17'($urandom_range(17'h1FFFF, 17'h10001));
      3:       return 17'd1;
      4:       return 17'hFFFF;
      5:       return 17'($urandom_range(255, 1));
      default: return 17'($urandom_range(17'hFFFF, 1));
    endcase
  endfunction

  // Offers one control point and waits until the transaction is accepted.
  task automatic push_point(logic [16:0] t, logic [31:0] px, logic [31:0] py,
                            logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= S_W'({$urandom, $urandom, $urandom});
      s_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, py, px, t};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_point(t, px, py, last);
  endtask

  // Sends one curve of random points closed with the given parameter.
  task automatic push_curve(int unsigned npts, logic [16:0] t_last);
    for (int unsigned i = 1; i < npts; i++)
      push_point(17'($urandom), rand_coord(), rand_coord(), 1'b0);
    push_point(t_last, rand_coord(), rand_coord(), 1'b1);
  endtask

  // Random curves until the phase has sent its share of points.
  task automatic random_phase(int unsigned n_items, bit force_overflow);
    int unsigned start;
    int unsigned npts;
    int unsigned pick;
    start = sb.points_seen;
    while (sb.points_seen - start < n_items) begin
      pick = $urandom_range(9);
      if (force_overflow) begin
        npts           = $urandom_range(MAX_PTS + 4, MAX_PTS + 1);
        force_overflow = 0;
      end else if (pick < 7) begin
        npts = $urandom_range(5, 1);
      end else if (pick < 9) begin
        npts = $urandom_range(MAX_PTS, 6);
      end else begin
        npts = $urandom_range(MAX_PTS + 4, MAX_PTS + 1);
      end
      push_curve(npts, rand_last_t());
    end
  endtask

  // Sender waits with tvalid low until every pending result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single points, short curves, ends of t, extreme coordinates.
    push_point(17'h1FFFF, C_MAX, C_MIN, 1'b1);
    push_point(17'd12345, 32'h0, 32'hFFFF_FFFF, 1'b1);
    push_point(17'd0, C_MIN, C_MAX, 1'b0);
    push_point(17'd32768, C_MAX, C_MIN, 1'b1);
    push_point(17'h1FFFF, C_MAX, 32'h0, 1'b0);
    push_point(17'd0, C_MIN, 32'hFFFF_FFFF, 1'b1);
    push_point(17'd0, 32'h1, 32'h2, 1'b0);
    push_point(T_ONE, C_MIN, C_MAX, 1'b1);
    push_point(17'd0, C_MAX, C_MAX, 1'b0);
    push_point(T_ONE + 17'd1, C_MIN, C_MIN, 1'b1);
    push_curve(3, 17'd1);
    push_curve(4, 17'hFFFF);
    push_curve(5, 17'd40000);

    // Sender mostly busy, receiver mostly stalled.
    random_phase(PHASE_ITEMS, 1'b1);
    drain_results();

    // Receiver mostly ready, sender mostly idle.
    send_idle_pct = 73;
    recv_idle_pct = 9;
    random_phase(PHASE_ITEMS, 1'b0);
    drain_results();

    // No idling, opened by a long output stall so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    random_phase(PHASE_ITEMS, 1'b0);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("Sent %0d control points in %0d curves, %0d of them over capacity.",
             sb.points_seen, sb.curves_seen, sb.overflow_curves);
    $display("Checked %0d curve points, %0d mismatches.", sb.results_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
